### rtl/wob_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wob_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int MAX_COMPONENTS = 16;
    localparam int PHASE_BITS     = 24;

    localparam int TAB_AW  = $clog2(TABLE_DEPTH);
    localparam int COMP_AW = $clog2(MAX_COMPONENTS);

    // configuration register widths, fixed by the register map
    localparam int SIZE_W  = 11;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 11;
    localparam int CFG_AW  = 1;

    localparam logic [CFG_AW-1:0] CFG_TABLE_SIZE      = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_COMPONENT_COUNT = 1'd1;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = SIZE_W'(1024);

    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_WRITE_TABLE = 2'd1;
    localparam logic [1:0] OP_WRITE_COMP  = 2'd2;

    localparam int SAMPLE_W = 24;

    typedef struct packed {
        logic [1:0]               op;
        logic [9:0]               table_index;
        logic signed [15:0]       table_value;
        logic [3:0]               component_index;
        logic [23:0]              phase_step;
        logic signed [15:0]       amplitude;
        logic [23:0]              start_phase;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } out_item_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0] step;
        logic signed [15:0]    gain;
        logic [PHASE_BITS-1:0] phase;
    } comp_entry_t;

endpackage
`default_nettype wire

### rtl/wavetable_oscillator_bank_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Bank of up to 16 wavetable oscillators sharing one 1024-word wave table, summed into a
// 24-bit sample. A tick runs the active
// components through a five-stage pipeline (component memory read, phase-to-index multiply
// with phase write-back, table read, gain multiply, accumulate), one component entering per
// cycle; the sum is saturated into the result word once the pipeline has drained.
// New input is taken only between ticks; a finished word waits in the output register, and
// a tick that finishes while it is still full waits in turn.
module wavetable_oscillator_bank_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire wob_pkg::in_item_t              s_item,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output wob_pkg::out_item_t                  m_item,
    input  wire logic                           cfg_we,
    input  wire logic [wob_pkg::CFG_AW-1:0]     cfg_index,
    input  wire logic [wob_pkg::CFG_W-1:0]      cfg_data
);
    import wob_pkg::*;

    localparam int ACC_W = 32 + COMP_AW + 1;
    localparam int Q_RAW_W = ACC_W - 15;
    localparam int Q_W = (Q_RAW_W > SAMPLE_W) ? Q_RAW_W : SAMPLE_W;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    state_t                   state_reg;
    logic [SIZE_W-1:0]        table_size_reg;
    logic [CNT_W-1:0]         component_count_reg;
    logic [CNT_W-1:0]         iss_cnt_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COMP_AW-1:0]       addr1_reg;
    logic [TAB_AW-1:0]        idx2_reg;
    logic signed [15:0]       gain2_reg, gain3_reg;
    logic signed [31:0]       prod4_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_valid_reg;
    out_item_t                m_item_reg;

    logic                     s_fire;
    logic [SIZE_W-1:0]        size_eff;
    logic [CNT_W-1:0]         count_eff;
    logic                     issue;
    logic                     drained;
    comp_entry_t              comp_rd;
    comp_entry_t              comp_wr;
    logic [COMP_AW-1:0]       comp_waddr;
    logic                     comp_we;
    logic [$bits(comp_entry_t)-1:0] comp_rd_bits;
    logic [15:0]              tab_rd;
    logic [PHASE_BITS+SIZE_W-1:0] idx_prod;
    logic signed [Q_RAW_W-1:0] q_raw;
    logic signed [Q_W-1:0]    q_ext;
    out_item_t                result;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // table size zero reads entry 0; oversize values clamp to the depth
    always_comb begin
        if (table_size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end else if (table_size_reg > SIZE_W'(TABLE_DEPTH)) begin
            size_eff = SIZE_W'(TABLE_DEPTH);
        end else begin
            size_eff = table_size_reg;
        end
        if (component_count_reg > CNT_W'(MAX_COMPONENTS)) begin
            count_eff = CNT_W'(MAX_COMPONENTS);
        end else begin
            count_eff = component_count_reg;
        end
    end

    assign issue   = (state_reg == ST_RUN) && (iss_cnt_reg < count_eff);
    assign drained = (iss_cnt_reg >= count_eff) && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    assign comp_rd  = comp_entry_t'(comp_rd_bits);
    assign idx_prod = PHASE_BITS'(comp_rd.phase) * size_eff;

    // component memory: setup writes while idle, phase write-back while running
    always_comb begin
        if (state_reg == ST_RUN) begin
            comp_we       = v1_reg;
            comp_waddr    = addr1_reg;
            comp_wr.step  = comp_rd.step;
            comp_wr.gain  = comp_rd.gain;
            comp_wr.phase = comp_rd.phase + comp_rd.step;
        end else begin
            comp_we       = s_fire && (s_item.op == OP_WRITE_COMP);
            comp_waddr    = s_item.component_index[COMP_AW-1:0];
            comp_wr.step  = s_item.phase_step[PHASE_BITS-1:0];
            comp_wr.gain  = s_item.amplitude;
            comp_wr.phase = s_item.start_phase[PHASE_BITS-1:0];
        end
    end

    wob_ram #(
        .WIDTH ($bits(comp_entry_t)),
        .DEPTH (MAX_COMPONENTS)
    ) u_comp_ram (
        .aclk    (aclk),
        .wr_en   (comp_we),
        .wr_addr (comp_waddr),
        .wr_data (comp_wr),
        .rd_addr (iss_cnt_reg[COMP_AW-1:0]),
        .rd_data (comp_rd_bits)
    );

    wob_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .aclk    (aclk),
        .wr_en   (s_fire && (s_item.op == OP_WRITE_TABLE)),
        .wr_addr (s_item.table_index[TAB_AW-1:0]),
        .wr_data (s_item.table_value),
        .rd_addr (idx2_reg),
        .rd_data (tab_rd)
    );

    // floor shift, then saturate to the sample width
    always_comb begin
        q_raw = Q_RAW_W'(acc_reg >>> 15);
        q_ext = Q_W'(q_raw);
        result.clipped = 1'b0;
        result.sample_out = q_ext[SAMPLE_W-1:0];
        if (q_ext > Q_W'(SAMPLE_MAX)) begin
            result.sample_out = SAMPLE_MAX;
            result.clipped    = 1'b1;
        end else if (q_ext < Q_W'(SAMPLE_MIN)) begin
            result.sample_out = SAMPLE_MIN;
            result.clipped    = 1'b1;
        end
    end

    // datapath stages, no reset needed
    always_ff @(posedge aclk) begin
        addr1_reg <= iss_cnt_reg[COMP_AW-1:0];
        idx2_reg  <= idx_prod[PHASE_BITS +: TAB_AW];
        gain2_reg <= comp_rd.gain;
        gain3_reg <= gain2_reg;
        prod4_reg <= $signed(tab_rd) * gain3_reg;
        if (s_fire) begin
            acc_reg <= '0;
        end else if (v4_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod4_reg);
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_item_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            table_size_reg      <= TABLE_SIZE_RESET;
            component_count_reg <= '0;
            iss_cnt_reg         <= '0;
            v1_reg              <= 1'b0;
            v2_reg              <= 1'b0;
            v3_reg              <= 1'b0;
            v4_reg              <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TABLE_SIZE:      table_size_reg      <= cfg_data[SIZE_W-1:0];
                    CFG_COMPONENT_COUNT: component_count_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (issue) begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end

            // load a finished sum when the output register frees up, else drop on accept
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_item.op == OP_TICK) begin
                        iss_cnt_reg <= '0;
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (drained) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold the sum until the output register frees up
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/wob_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module wob_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### verif/wavetable_oscillator_bank_core_tb.sv
`timescale 1ns / 1ps
module wavetable_oscillator_bank_core_tb;
    import wob_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         LONG_HOLD     = 400;
    localparam int         RANDOM_WORDS  = 160;
    localparam longint     CYCLE_LIMIT   = 1000000;
    localparam longint     SAMPLE_MAX    = 64'sd8388607;
    localparam longint     SAMPLE_MIN    = -64'sd8388608;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    in_item_t          s_item    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    out_item_t         m_item;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // words waiting for the driver, and samples the bank should produce
    in_item_t  stim_q[$];
    out_item_t sample_q[$];

    // shadow of the bank
    logic signed [15:0]    wave_mem  [TABLE_DEPTH];
    logic [PHASE_BITS-1:0] osc_step  [MAX_COMPONENTS];
    logic signed [15:0]    osc_gain  [MAX_COMPONENTS];
    logic [PHASE_BITS-1:0] osc_phase [MAX_COMPONENTS];
    logic [SIZE_W-1:0]     size_reg  = TABLE_SIZE_RESET;
    logic [CNT_W-1:0]      count_reg = '0;

    int        n_tick = 0, n_tab = 0, n_comp = 0, n_cfg = 0, n_random = 0;
    int        n_checked = 0, n_fail = 0;
    int        hold_requests = 0, hold_served = 0;
    longint    cycles = 0;
    out_item_t want_word;

    always #10 aclk = ~aclk;

    wavetable_oscillator_bank_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic out_item_t oscillate_tick();
        out_item_t       res;
        longint unsigned size;
        longint unsigned ph;
        longint unsigned idx;
        int              count;
        longint          acc;
        longint          q;
        size = size_reg;
        if (size == 0) size = 1;
        if (size > TABLE_DEPTH) size = TABLE_DEPTH;
        count = (count_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(count_reg);
        acc = 0;
        for (int j = 0; j < count; j++) begin
            ph  = osc_phase[j];
            idx = (ph * size) >> PHASE_BITS;
            acc += longint'(wave_mem[idx]) * longint'(osc_gain[j]);
            osc_phase[j] = osc_phase[j] + osc_step[j];
        end
        // arithmetic shift floors toward minus infinity
        q = acc >>> 15;
        res.clipped = 1'b0;
        if (q > SAMPLE_MAX) begin
            q = SAMPLE_MAX;
            res.clipped = 1'b1;
        end else if (q < SAMPLE_MIN) begin
            q = SAMPLE_MIN;
            res.clipped = 1'b1;
        end
        res.sample_out = q[SAMPLE_W-1:0];
        return res;
    endfunction

    function automatic void apply_word(input in_item_t w);
        case (w.op)
            OP_TICK: begin
                sample_q.push_back(oscillate_tick());
                n_tick++;
            end
            OP_WRITE_TABLE: begin
                wave_mem[w.table_index] = w.table_value;
                n_tab++;
            end
            OP_WRITE_COMP: begin
                osc_step[w.component_index]  = w.phase_step;
                osc_gain[w.component_index]  = w.amplitude;
                osc_phase[w.component_index] = w.start_phase;
                n_comp++;
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t rand_word();
        in_item_t w;
        w = {$urandom, $urandom, $urandom};
        return w;
    endfunction

    function automatic void push_tick();
        in_item_t w;
        w    = rand_word();
        w.op = OP_TICK;
        stim_q.push_back(w);
    endfunction

    function automatic void push_table(input int idx, input int val);
        in_item_t w;
        w             = rand_word();
        w.op          = OP_WRITE_TABLE;
        w.table_index = 10'(idx);
        w.table_value = 16'(val);
        stim_q.push_back(w);
    endfunction

    function automatic void push_comp(input int ci, input int step,
                                      input int amp, input int ph);
        in_item_t w;
        w                 = rand_word();
        w.op              = OP_WRITE_COMP;
        w.component_index = 4'(ci);
        w.phase_step      = 24'(step);
        w.amplitude       = 16'(amp);
        w.start_phase     = 24'(ph);
        stim_q.push_back(w);
    endfunction

    function automatic void push_junk();
        in_item_t w;
        w    = rand_word();
        w.op = OP_UNUSED;
        stim_q.push_back(w);
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return TABLE_DEPTH;
            3: return $urandom_range(TABLE_DEPTH + 1, 2047);
            4: return $urandom_range(2, 16);
            default: return $urandom_range(1, TABLE_DEPTH);
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return MAX_COMPONENTS;
            2: return $urandom_range(MAX_COMPONENTS + 1, 31);
            default: return $urandom_range(1, MAX_COMPONENTS);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_TABLE_SIZE) size_reg = val[SIZE_W-1:0];
        else count_reg = val[CNT_W-1:0];
        n_cfg++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_bank(input int size, input int count);
        logic [CFG_W-CNT_W-1:0] junk;
        junk = (CFG_W-CNT_W)'($urandom);
        write_reg(CFG_TABLE_SIZE, CFG_W'(size));
        // upper bits of the count word are don't-care
        write_reg(CFG_COMPONENT_COUNT, {junk, CNT_W'(count)});
    endtask

    // wait until the bank is idle with nothing owed
    task automatic settle();
        @(negedge aclk);
        while (stim_q.size() != 0 || s_valid || sample_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_tick();
                n_random++;
            end else if (r < 78) begin
                push_table($urandom, $urandom);
                n_random++;
            end else if (r < 95) begin
                push_comp($urandom,
                          ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4096),
                          $urandom, $urandom);
                n_random++;
            end else begin
                push_junk();
            end
        end
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || stim_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_item  <= stim_q.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: short stalls, free-running stretches, and long hold-offs on request
    int stall_left = 0;
    int free_left  = 0;
    int hold_left  = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (free_left > 0) begin
            free_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2: begin
                    stall_left = $urandom_range(0, 11);
                    m_ready <= 1'b0;
                end
                3: begin
                    free_left = $urandom_range(50, 150);
                    m_ready <= 1'b1;
                end
                default: m_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) apply_word(s_item);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sample_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected word: sample_out %0d clipped %0b",
                             m_item.sample_out, m_item.clipped);
            end else begin
                want_word = sample_q.pop_front();
                n_checked++;
                if (m_item.sample_out !== want_word.sample_out ||
                    m_item.clipped !== want_word.clipped) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch on word %0d: sample_out exp %0d got %0d, %s%0b got %0b",
                                 n_checked, want_word.sample_out, m_item.sample_out,
                                 "clipped exp ", want_word.clipped, m_item.clipped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run exceeded %0d cycles, %0d words still owed", CYCLE_LIMIT,
                     sample_q.size());
            $display("wavetable_oscillator_bank_core_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int phase_no;
        phase_no = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // load every table entry and component so no read hits unwritten state
        for (int i = 0; i < TABLE_DEPTH; i++) push_table(i, $urandom);
        for (int c = 0; c < MAX_COMPONENTS; c++) push_comp(c, $urandom, $urandom, $urandom);

        push_table(0, 16'h8000);
        push_table(TABLE_DEPTH - 1, 16'h7FFF);
        push_comp(0, 24'h000000, 16'h8000, 24'h000000);
        push_comp(1, 24'hFFFFFF, 16'h7FFF, 24'hFFFFFF);
        push_junk();
        push_tick();
        settle();
        set_bank(TABLE_DEPTH, MAX_COMPONENTS);
        repeat (3) push_tick();
        settle();
        // zero size reads entry 0 only
        set_bank(0, 2);
        repeat (2) push_tick();
        settle();
        // both registers above range saturate
        set_bank(2047, 31);
        repeat (2) push_tick();
        settle();
        set_bank(1, 1);
        push_tick();
        settle();

        while (n_random < RANDOM_WORDS) begin
            if (phase_no == 2) begin
                // stall the output long enough for the input to back up
                set_bank($urandom_range(1, TABLE_DEPTH), MAX_COMPONENTS);
                hold_requests++;
                repeat (40) push_tick();
                random_phase(40);
            end else begin
                set_bank(pick_size(), pick_count());
                random_phase($urandom_range(20, 50));
            end
            settle();
            phase_no++;
        end

        settle();
        $display("%0d ticks, %0d table writes, %0d component writes, %0d register writes",
                 n_tick, n_tab, n_comp, n_cfg);
        $display("%0d settings, %0d sample words checked, %0d failures",
                 phase_no + 5, n_checked, n_fail);
        if (n_fail == 0 && sample_q.size() == 0) begin
            $display("wavetable_oscillator_bank_core_tb OK");
        end else begin
            $display("wavetable_oscillator_bank_core_tb NOT OK");
        end
        $finish;
    end

endmodule

### wavetable_oscillator_bank_core.f
rtl/wob_pkg.sv
rtl/wob_ram.sv
rtl/wavetable_oscillator_bank_core.sv
verif/wavetable_oscillator_bank_core_tb.sv
